// ===== sv/lpd_pkg.sv =====
// Shared types and constants of the length-prefixed message deframer.
package lpd_pkg;

    localparam int CHANNELS     = 16;
    localparam int HEADER_BYTES = 4;

    localparam int LEN_W     = 32;
    localparam int LEN_BYTES = 4;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HC_W      = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    typedef struct packed {
        logic [3:0] channel;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] out_channel;
        logic [7:0] payload_byte;
        logic       end_of_message;
        logic       empty_message;
        logic       length_error;
    } t_out_item;

    typedef struct packed {
        logic             in_payload;
        logic [HC_W-1:0]  header_bytes_seen;
        logic [LEN_W-1:0] length_or_remaining;
    } t_ctx;

endpackage

// ===== sv/lpd_engine.sv =====
// Per-channel context memory with its read-modify-write stage and forwarding.
module lpd_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  lpd_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_res_vld,
    output lpd_pkg::t_out_item o_res
);
    import lpd_pkg::*;

    t_ctx               r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_ctx_vld;
    t_ctx               r_rd_ctx;
    logic               r_s1_vld;
    logic [3:0]         r_s1_ch;
    logic [7:0]         r_s1_byte;
    logic               r_fw_vld;
    logic [3:0]         r_fw_ch;
    t_ctx               r_fw_ctx;

    logic [IDX_W-1:0]   s1_idx;
    logic [IDX_W-1:0]   in_idx;
    t_ctx               cur_ctx;
    t_ctx               n_ctx;
    logic [LEN_W-1:0]   rem;
    logic [LEN_W-1:0]   hdr_len;
    logic [1:0]         lane;
    logic               last_hdr;

    assign in_idx = IDX_W'(i_item.channel);
    assign s1_idx = IDX_W'(r_s1_ch);

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd_ctx  <= r_mem[in_idx];
            r_s1_ch   <= i_item.channel;
            r_s1_byte <= i_item.data_byte;
        end
        if (r_s1_vld) begin
            r_mem[s1_idx] <= n_ctx;
        end
        r_fw_ch  <= r_s1_ch;
        r_fw_ctx <= n_ctx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_ctx_vld <= '0;
        end else begin
            r_s1_vld <= i_acc;
            r_fw_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_ctx_vld[s1_idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_fw_vld && (r_fw_ch == r_s1_ch)) begin
            cur_ctx = r_fw_ctx;
        end else if (!r_ctx_vld[s1_idx]) begin
            cur_ctx = '0;
        end else begin
            cur_ctx = r_rd_ctx;
        end
    end

    always_comb begin
        n_ctx     = cur_ctx;
        o_res_vld = 1'b0;
        o_res     = '0;
        o_res.out_channel = r_s1_ch;
        rem       = cur_ctx.length_or_remaining - LEN_W'(1);
        lane      = 2'(cur_ctx.header_bytes_seen);
        last_hdr  = (int'(cur_ctx.header_bytes_seen) == HEADER_BYTES - 1);
        hdr_len   = (cur_ctx.header_bytes_seen == '0) ? '0 : cur_ctx.length_or_remaining;
        if (int'(cur_ctx.header_bytes_seen) < LEN_BYTES) begin
            hdr_len[{lane, 3'b000} +: 8] = hdr_len[{lane, 3'b000} +: 8] | r_s1_byte;
        end
        if (cur_ctx.in_payload) begin
            n_ctx.length_or_remaining = rem;
            n_ctx.in_payload          = (rem != '0);
            o_res_vld                 = 1'b1;
            o_res.payload_byte        = r_s1_byte;
            o_res.end_of_message      = (rem == '0);
        end else if (!last_hdr) begin
            n_ctx.header_bytes_seen   = HC_W'(cur_ctx.header_bytes_seen + 1'b1);
            n_ctx.length_or_remaining = hdr_len;
        end else begin
            n_ctx.header_bytes_seen = '0;
            if (hdr_len[LEN_W-1]) begin
                n_ctx.length_or_remaining = '0;
                o_res_vld                 = 1'b1;
                o_res.length_error        = 1'b1;
            end else if (hdr_len == '0) begin
                n_ctx.length_or_remaining = '0;
                o_res_vld                 = 1'b1;
                o_res.end_of_message      = 1'b1;
                o_res.empty_message       = 1'b1;
            end else begin
                n_ctx.length_or_remaining = hdr_len;
                n_ctx.in_payload          = 1'b1;
            end
        end
        if (!r_s1_vld) begin
            o_res_vld = 1'b0;
        end
    end

    assign o_busy = r_s1_vld;

endmodule

// ===== sv/lpd_out_queue.sv =====
// Small output queue that decouples result delivery from the context pipeline.
module lpd_out_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  lpd_pkg::t_out_item      i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output lpd_pkg::t_out_item      o_item,
    output logic [lpd_pkg::OQ_CNT_W-1:0] o_level
);
    import lpd_pkg::*;

    t_out_item           r_buf [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign o_level = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == OQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == OQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/length_prefixed_message_deframer.sv =====
// Top level of the multi-channel length-prefixed message deframer.
//
//  Channel | Direction | Handshake                    | Item
//  --------+-----------+------------------------------+-----------
//  in      | to block  | i_in_valid / o_in_ready      | i_in_item
//  out     | from block| o_out_valid / i_out_ready    | o_out_item
//
// One item is taken every cycle while o_in_ready is high; results are queued.
// The rate is set by the single read-modify-write of the context memory,
// with the previous write forwarded when two items share a channel.
// Reset clears per-channel valid bits, so no clearing pass over the memory.
// A stalled output fills a three-entry queue; o_in_ready drops once the queued
// results and the item in flight make three.
module length_prefixed_message_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpd_pkg::t_out_item o_out_item
);
    import lpd_pkg::*;

    logic                acc;
    logic                busy;
    logic                res_vld;
    t_out_item           res;
    logic [OQ_CNT_W-1:0] level;
    logic [OQ_CNT_W:0]   pending;

    assign pending    = {1'b0, level} + (OQ_CNT_W + 1)'(busy);
    assign o_in_ready = (int'(pending) < OQ_DEPTH);
    assign acc        = i_in_valid && o_in_ready && (int'(i_in_item.channel) < CHANNELS);

    lpd_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_item    (i_in_item),
        .o_busy    (busy),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    lpd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_item  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item),
        .o_level (level)
    );

endmodule

// ===== sv/lpd_checker.sv =====
// Port-level checks of the deframer, bound to its top level.
module lpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lpd_pkg::t_out_item o_out_item
);
    import lpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("Result item changed while stalled.");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("Block not empty and ready after reset.");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.empty_message |->
            o_out_item.end_of_message && !o_out_item.length_error &&
            (o_out_item.payload_byte == 8'd0))
        else $error("Malformed empty-message marker.");

    a_error_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.length_error |->
            !o_out_item.end_of_message && !o_out_item.empty_message &&
            (o_out_item.payload_byte == 8'd0))
        else $error("Malformed length-error marker.");

endmodule

bind length_prefixed_message_deframer lpd_checker u_lpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== dv/lpd_deframe_checker.sv =====
// Checker for the deframer: predicts per-channel framing results and compares them.
module lpd_deframe_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  lpd_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  lpd_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_empties,
    output int                 o_len_errors
);
    import lpd_pkg::*;

    logic             awaiting_payload [CHANNELS];
    int unsigned      hdr_count [CHANNELS];
    logic [LEN_W-1:0] len_left [CHANNELS];
    t_out_item        expected_results [$];

    task automatic expect_result(input t_out_item res);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic deframe_byte(input t_in_item item);
        int unsigned ch;
        int unsigned pos;
        t_out_item   res;
        ch = item.channel;
        res = '0;
        res.out_channel = item.channel;
        if (ch >= CHANNELS) begin
            return;
        end
        if (awaiting_payload[ch]) begin
            len_left[ch] = len_left[ch] - 1;
            res.payload_byte = item.data_byte;
            if (len_left[ch] == '0) begin
                awaiting_payload[ch] = 1'b0;
                res.end_of_message = 1'b1;
            end
            expect_result(res);
            return;
        end
        pos = hdr_count[ch];
        if (pos == 0) begin
            len_left[ch] = '0;
        end
        if (pos < LEN_BYTES) begin
            len_left[ch] = len_left[ch] | (LEN_W'(item.data_byte) << (8 * pos));
        end
        pos++;
        if (pos < HEADER_BYTES) begin
            hdr_count[ch] = pos;
            return;
        end
        hdr_count[ch] = 0;
        if (len_left[ch][LEN_W-1]) begin
            len_left[ch] = '0;
            res.length_error = 1'b1;
            expect_result(res);
        end else if (len_left[ch] == '0) begin
            res.end_of_message = 1'b1;
            res.empty_message = 1'b1;
            expect_result(res);
        end else begin
            awaiting_payload[ch] = 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t %s: expected ch=%0d byte=%02h eom=%b empty=%b err=%b,",
                     $time, what, want.out_channel, want.payload_byte,
                     want.end_of_message, want.empty_message, want.length_error);
            $display("    got ch=%0d byte=%02h eom=%b empty=%b err=%b",
                     got.out_channel, got.payload_byte, got.end_of_message,
                     got.empty_message, got.length_error);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            note_mismatch("result with nothing expected", '0, got);
            return;
        end
        want = expected_results.pop_front();
        o_checked++;
        if (want.empty_message) begin
            o_empties++;
        end
        if (want.length_error) begin
            o_len_errors++;
        end
        if (got.out_channel !== want.out_channel
                || got.payload_byte !== want.payload_byte
                || got.end_of_message !== want.end_of_message
                || got.empty_message !== want.empty_message
                || got.length_error !== want.length_error) begin
            note_mismatch("result mismatch", want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                awaiting_payload[c] = 1'b0;
                hdr_count[c] = 0;
                len_left[c] = '0;
            end
            expected_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_empties    = 0;
            o_len_errors = 0;
        end else begin
            // A result is registered after its item is taken, so the output is checked first.
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_in_item);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== dv/length_prefixed_message_deframer_tb.sv =====
// Testbench top of the deframer: framed byte stimulus, random idling and the verdict.
module length_prefixed_message_deframer_tb;
    import lpd_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Channel in the top nibble, byte below: bit-31 errors, an empty message and
    // short messages, partly interleaved across channels.
    localparam t_in_item DIRECTED_BYTES [23] = '{
        12'h301, 12'h5ff, 12'h300, 12'h5ff, 12'h300, 12'h5ff, 12'h300, 12'h5ff, 12'h3ff,
        12'h000, 12'h000, 12'h000, 12'h000,
        12'hf00, 12'hf00, 12'hf00, 12'hf80,
        12'h802, 12'h800, 12'h800, 12'h800, 12'h800, 12'h8aa
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;

    int mismatches;
    int pending;
    int checked;
    int empties;
    int len_errors;

    logic [7:0]  chan_bytes [CHANNELS][$];
    int unsigned queued = 0;

    length_prefixed_message_deframer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    lpd_deframe_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_empties    (empties),
        .o_len_errors (len_errors)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 2) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
    end

    task automatic send_byte(input t_in_item item);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_item <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic enqueue_byte(input int unsigned ch, input logic [7:0] value);
        chan_bytes[ch].insert(chan_bytes[ch].size(), value);
    endtask

    task automatic queue_frame(input int unsigned ch);
        logic [31:0] len;
        int unsigned kind;
        int          i;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            len = '0;
        end else if (kind < 25) begin
            len = $urandom() | 32'h8000_0000;
        end else if (kind < 28) begin
            len = $urandom_range(256, 300);
        end else begin
            len = $urandom_range(1, 12);
        end
        for (i = 0; i < LEN_BYTES; i++) begin
            enqueue_byte(ch, len[8*i +: 8]);
        end
        queued += LEN_BYTES;
        if (!len[31]) begin
            repeat (len) begin
                enqueue_byte(ch, 8'($urandom()));
            end
            queued += len;
        end
    endtask

    initial begin
        t_in_item    item;
        int unsigned ch;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[k]) begin
            send_byte(DIRECTED_BYTES[k]);
        end

        while (queued < RANDOM_ITEMS) begin
            queue_frame($urandom_range(0, CHANNELS - 1));
        end

        // Half the time the same channel goes again, so back-to-back context updates occur.
        ch = 0;
        while (queued > 0) begin
            if ($urandom_range(0, 1) == 0 || chan_bytes[ch].size() == 0) begin
                do begin
                    ch = $urandom_range(0, CHANNELS - 1);
                end while (chan_bytes[ch].size() == 0);
            end
            if (queued <= CALM_ITEMS && !calm) begin
                calm <= 1'b1;
            end
            item.channel = ch[3:0];
            item.data_byte = chan_bytes[ch].pop_front();
            queued--;
            send_byte(item);
        end
        in_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes on %0d channels: normal, zero-length and bit-31 headers.",
                 bytes_sent, CHANNELS);
        $display("Checked %0d results, %0d empty markers and %0d length errors among them.",
                 checked, empties, len_errors);
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
